FILE: rtl/edger_dog_bone_width_recovery_unit_assert.svh
// Assertion macros shared by the checker of the dog-bone width recovery unit.
`ifndef EDGER_DOG_BONE_WIDTH_RECOVERY_UNIT_ASSERT_SVH
`define EDGER_DOG_BONE_WIDTH_RECOVERY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EDR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("edr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EDR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("edr assertion failed");

`endif

FILE: rtl/edr_pkg.sv
// Types, constants and constant functions of the dog-bone width recovery unit.
`timescale 1ns / 1ps
`default_nettype none
package edr_pkg;

  // Fixed-point formats.
  localparam int FracBits = 8;
  localparam int LgQ = 28;
  localparam logic [23:0] DiamReset = 24'(1 << FracBits);

  // Lanes of the log2 pipeline.
  localparam int NumLanes = 5;
  localparam int LaneWb = 0;
  localparam int LaneWa = 1;
  localparam int LaneDf = 2;
  localparam int LaneHt = 3;
  localparam int LaneDm = 4;

  // Exponents in Q24: r1, h/D, D/wb, wb/wa.
  localparam logic [26:0] CoefR1 = 27'd1056965;
  localparam logic [26:0] CoefHd = 27'd7398753;
  localparam logic [26:0] CoefDw = 27'd16592667;
  localparam logic [26:0] CoefWw = 27'd127355847;

  // log2(1.877 / ln 2) in Q28, and the exponent limits.
  localparam logic signed [39:0] LogScaleC = 40'sd385794103;
  localparam logic signed [39:0] MBig = 40'sd1342177280;
  localparam logic signed [39:0] MTiny = -40'sd10737418240;
  localparam logic [33:0] E2Big = 34'd4831838208;

  // Per-item flags that travel down the pipeline.
  typedef struct packed {
    logic        err;
    logic        unity;
    logic        zero;
    logic        tiny;
    logic        gz;
    logic [23:0] diff;
  } meta_t;

  // Side data of the exp2 pipeline: flags and the shift applied afterward.
  typedef struct packed {
    meta_t              meta;
    logic signed [6:0]  shift;
  } side_t;

  typedef logic [NumLanes-1:0][23:0] lane_x_t;
  typedef logic [NumLanes-1:0][32:0] lane_lg_t;

  // Integer square root, evaluated at elaboration only.
  function automatic logic [63:0] edr_isqrt(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v = x;
    res = '0;
    bt = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(2^-idx) in Q30, by repeated square roots.
  function automatic logic [63:0] edr_root_q30(input int idx);
    logic [63:0] r;
    r = edr_isqrt(64'd1 << 61);
    for (int j = 1; j < idx; j++) begin
      r = edr_isqrt(r << 30);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/edger_dog_bone_width_recovery_unit.sv
// Throughput: one beat per cycle unless the output stalls; every step is a
// register stage, the longest chains being the 28-stage log2 squaring and the
// two 28-stage exp2 multipliers. A stalled output parks one result in a skid
// register and then holds the pipe. Reset (rst_ni low, asynchronous) clears all
// valid bits and sets the roll diameter to 1.0; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module edger_dog_bone_width_recovery_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [23:0] width_before, [47:24] width_after, [71:48] height_before
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [23:0] width_increase, [40:24] bone_factor, [47:41] zero
  output logic [47:0]      m_axis_tdata,
  // [0] error_code
  output logic             m_axis_tuser
);
  import edr_pkg::*;

  logic en;
  logic [23:0] diam_q;

  // Roll diameter register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diam_q <= DiamReset;
    end else if (cfg_we_i) begin
      diam_q <= cfg_wdata_i;
    end
  end

  // Input stage: validity checks and lane values.
  logic [23:0] in_wb, in_wa, in_ht, in_df;
  meta_t       meta0_d, meta0_q;
  lane_x_t     x0_d, x0_q;
  logic        vld0_q;
  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q, vld6_q, vld7_q, vld8_q, vld9_q;

  assign in_wb = s_axis_tdata[23:0];
  assign in_wa = s_axis_tdata[47:24];
  assign in_ht = s_axis_tdata[71:48];
  assign in_df = in_wb - in_wa;

  always_comb begin
    meta0_d.err   = (in_wb == '0) || (in_wa == '0) || (in_wa > in_wb) || (diam_q == '0);
    meta0_d.unity = (in_df == '0) || (in_ht == '0);
    meta0_d.zero  = 1'b0;
    meta0_d.tiny  = 1'b0;
    meta0_d.gz    = 1'b0;
    meta0_d.diff  = in_df;
    x0_d[LaneWb]  = in_wb;
    x0_d[LaneWa]  = in_wa;
    x0_d[LaneDf]  = in_df;
    x0_d[LaneHt]  = in_ht;
    x0_d[LaneDm]  = diam_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta0_q <= meta0_d;
      x0_q    <= x0_d;
    end
  end

  // Log2 of all five quantities.
  logic     vld_l;
  meta_t    meta_l;
  lane_lg_t lg_l;

  edr_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld0_q),
    .meta_i  (meta0_q),
    .x_i     (x0_q),
    .valid_o (vld_l),
    .meta_o  (meta_l),
    .lg_o    (lg_l)
  );

  // Log ratios, then coefficient products split into two partials each.
  logic signed [34:0] dl_q   [4];
  logic        [42:0] plo_q  [4];
  logic signed [46:0] phi_q  [4];
  logic signed [63:0] term_q [4];
  logic signed [63:0] sum_q;
  meta_t              meta1_q, meta2_q, meta3_q, meta4_q;
  logic [26:0]        coef [4];
  logic [42:0]        plo_d [4];
  logic signed [46:0] phi_d [4];
  logic signed [46:0] ca [4];
  logic signed [46:0] hb [4];

  assign coef[0] = CoefR1;
  assign coef[1] = CoefHd;
  assign coef[2] = CoefDw;
  assign coef[3] = CoefWw;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ca[j]    = {20'b0, coef[j]};
      hb[j]    = {{28{dl_q[j][34]}}, dl_q[j][34:16]};
      plo_d[j] = 43'(coef[j]) * 43'(dl_q[j][15:0]);
      phi_d[j] = ca[j] * hb[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dl_q[0] <= $signed({2'b00, lg_l[LaneDf]}) - $signed({2'b00, lg_l[LaneWb]});
      dl_q[1] <= $signed({2'b00, lg_l[LaneHt]}) - $signed({2'b00, lg_l[LaneDm]});
      dl_q[2] <= $signed({2'b00, lg_l[LaneDm]}) - $signed({2'b00, lg_l[LaneWb]});
      dl_q[3] <= $signed({2'b00, lg_l[LaneWb]}) - $signed({2'b00, lg_l[LaneWa]});
      meta1_q <= meta_l;
      for (int j = 0; j < 4; j++) begin
        plo_q[j]  <= plo_d[j];
        phi_q[j]  <= phi_d[j];
        term_q[j] <= ($signed({{17{phi_q[j][46]}}, phi_q[j]}) <<< 16)
                   + $signed({21'b0, plo_q[j]});
      end
      meta2_q <= meta1_q;
      meta3_q <= meta2_q;
      sum_q   <= term_q[0] + term_q[1] + term_q[2] + term_q[3] + 64'sd8388608;
      meta4_q <= meta3_q;
    end
  end

  // Rounded exponent, range checks, split into shift and fraction.
  logic signed [63:0] shr5;
  logic signed [39:0] m5;
  logic signed [11:0] n5;
  side_t              side5_d, side5_q;
  logic [27:0]        frac5_q;

  always_comb begin
    shr5 = sum_q >>> 24;
    m5   = $signed(shr5[39:0]) + LogScaleC;
    n5   = $signed(m5[39:28]);
    side5_d.meta      = meta4_q;
    side5_d.meta.zero = meta4_q.zero || (m5 >= MBig);
    side5_d.meta.tiny = (m5 < MTiny);
    side5_d.shift     = $signed(n5[6:0]) - 7'sd2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side5_q <= side5_d;
      frac5_q <= m5[27:0];
    end
  end

  // First exp2: E2 = 2^M.
  logic        vld_e1;
  logic [30:0] pow_e1;
  side_t       side_e1;

  edr_exp2 u_exp2_m (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld5_q),
    .frac_i  (frac5_q),
    .side_i  (side5_q),
    .valid_o (vld_e1),
    .pow_o   (pow_e1),
    .side_o  (side_e1)
  );

  // Scale by the integer part, then split E2 into k and g.
  logic [33:0] e2_d, e2_q;
  logic [6:0]  ns6;
  meta_t       meta6_q;
  side_t       side7_d, side7_q;
  logic [27:0] frac7_q;

  always_comb begin
    ns6 = 7'(-side_e1.shift);
    if (side_e1.meta.tiny) begin
      e2_d = '0;
    end else if (!side_e1.shift[6]) begin
      e2_d = {3'b000, pow_e1} << side_e1.shift[1:0];
    end else begin
      e2_d = {3'b000, pow_e1} >> ns6[5:0];
    end
    side7_d.meta      = meta6_q;
    side7_d.meta.zero = meta6_q.zero || (e2_q >= E2Big);
    side7_d.meta.gz   = (e2_q[27:0] == '0);
    side7_d.shift     = $signed({2'b00, e2_q[32:28]});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e2_q    <= e2_d;
      meta6_q <= side_e1.meta;
      side7_q <= side7_d;
      frac7_q <= 28'(0) - e2_q[27:0];
    end
  end

  // Second exp2: 2^(1-g).
  logic        vld_e2;
  logic [30:0] pow_e2;
  side_t       side_e2;

  edr_exp2 u_exp2_f (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld7_q),
    .frac_i  (frac7_q),
    .side_i  (side7_q),
    .valid_o (vld_e2),
    .pow_o   (pow_e2),
    .side_o  (side_e2)
  );

  // Factor from 2^(1-g) shifted by k, then the special cases.
  logic [4:0]  k8;
  logic [31:0] a8;
  logic [32:0] rs8;
  logic [32:0] fs8;
  logic [16:0] f8_d, f8_q;
  meta_t       meta8_q;

  always_comb begin
    k8  = side_e2.shift[4:0];
    a8  = side_e2.meta.gz ? 32'h8000_0000 : {1'b0, pow_e2};
    rs8 = {1'b0, a8} + (33'd1 << (6'd14 + {1'b0, k8}));
    fs8 = rs8 >> (6'd15 + {1'b0, k8});
    if (side_e2.meta.err) begin
      f8_d = '0;
    end else if (side_e2.meta.unity) begin
      f8_d = 17'h10000;
    end else if (side_e2.meta.zero) begin
      f8_d = '0;
    end else begin
      f8_d = fs8[16:0];
    end
  end

  // Width increase, rounded.
  logic [40:0] wp9;
  logic [23:0] wi9_q;
  logic [16:0] bf9_q;
  logic        err9_q;

  assign wp9 = 41'(f8_q) * 41'(meta8_q.diff) + 41'd32768;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f8_q    <= f8_d;
      meta8_q <= side_e2.meta;
      wi9_q   <= wp9[39:16];
      bf9_q   <= f8_q;
      err9_q  <= meta8_q.err;
    end
  end

  // Valid bits of the stages outside the submodules.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
      vld7_q <= 1'b0;
      vld8_q <= 1'b0;
      vld9_q <= 1'b0;
    end else if (en) begin
      vld0_q <= s_axis_tvalid;
      vld1_q <= vld_l;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
      vld6_q <= vld_e1;
      vld7_q <= vld6_q;
      vld8_q <= vld_e2;
      vld9_q <= vld8_q;
    end
  end

  // Output skid register: takes one beat when the sink stalls.
  logic        skid_vld_q;
  logic [23:0] skid_wi_q;
  logic [16:0] skid_bf_q;
  logic        skid_err_q;

  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (m_axis_tready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (vld9_q && !m_axis_tready) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_vld_q) begin
      skid_wi_q  <= wi9_q;
      skid_bf_q  <= bf9_q;
      skid_err_q <= err9_q;
    end
  end

  assign m_axis_tvalid = skid_vld_q || vld9_q;
  assign m_axis_tdata  = skid_vld_q ? {7'b0, skid_bf_q, skid_wi_q} : {7'b0, bf9_q, wi9_q};
  assign m_axis_tuser  = skid_vld_q ? skid_err_q : err9_q;

endmodule
`default_nettype wire

FILE: rtl/edr_log2.sv
// Pipelined log2 in Q28 over five lanes, one fraction bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module edr_log2 (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire edr_pkg::meta_t  meta_i,
  input  wire edr_pkg::lane_x_t x_i,
  output logic                 valid_o,
  output edr_pkg::meta_t       meta_o,
  output edr_pkg::lane_lg_t    lg_o
);
  import edr_pkg::*;

  logic [NumLanes-1:0][31:0] m_q  [0:LgQ];
  logic [NumLanes-1:0][27:0] fr_q [0:LgQ];
  logic [NumLanes-1:0][4:0]  p_q  [0:LgQ];
  meta_t                     meta_q [0:LgQ];
  logic [LgQ:0]              vld_q;

  logic [NumLanes-1:0][31:0] m_d;
  logic [NumLanes-1:0][4:0]  p_d;

  // Leading-one position and normalized mantissa per lane.
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      p_d[l] = '0;
      for (int b = 0; b < 24; b++) begin
        if (x_i[l][b]) begin
          p_d[l] = 5'(b);
        end
      end
      m_d[l] = 32'(x_i[l]) << (5'd31 - p_d[l]);
    end
  end

  // Valid bits of all stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LgQ-1:0], valid_i};
    end
  end

  // Normalize stage.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]    <= m_d;
      p_q[0]    <= p_d;
      fr_q[0]   <= '0;
      meta_q[0] <= meta_i;
    end
  end

  // Squaring stages: each yields one fraction bit per lane.
  for (genvar gi = 1; gi <= LgQ; gi++) begin : g_sq
    logic [NumLanes-1:0][31:0] m_n;
    logic [NumLanes-1:0][27:0] fr_n;
    logic [NumLanes-1:0][63:0] sq;

    always_comb begin
      for (int l = 0; l < NumLanes; l++) begin
        sq[l] = 64'(m_q[gi-1][l]) * 64'(m_q[gi-1][l]);
        if (sq[l][63]) begin
          m_n[l]  = sq[l][63:32];
          fr_n[l] = {fr_q[gi-1][l][26:0], 1'b1};
        end else begin
          m_n[l]  = sq[l][62:31];
          fr_n[l] = {fr_q[gi-1][l][26:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[gi]    <= m_n;
        fr_q[gi]   <= fr_n;
        p_q[gi]    <= p_q[gi-1];
        meta_q[gi] <= meta_q[gi-1];
      end
    end
  end

  // Integer part over fraction per lane.
  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      lg_o[l] = {p_q[LgQ][l], fr_q[LgQ][l]};
    end
  end

  assign valid_o = vld_q[LgQ];
  assign meta_o  = meta_q[LgQ];

endmodule
`default_nettype wire

FILE: rtl/edr_exp2.sv
// Pipelined 2^f for a Q28 fraction, one conditional root multiply per stage.
`timescale 1ns / 1ps
`default_nettype none
module edr_exp2 (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  wire logic [27:0]    frac_i,
  input  wire edr_pkg::side_t side_i,
  output logic                valid_o,
  output logic [30:0]         pow_o,
  output edr_pkg::side_t      side_o
);
  import edr_pkg::*;

  logic [30:0] acc_q  [0:LgQ-1];
  logic [27:0] frac_q [0:LgQ-1];
  side_t       side_q [0:LgQ-1];
  logic [LgQ-1:0] vld_q;

  // Valid bits of all stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LgQ-2:0], valid_i};
    end
  end

  // Stage gi handles fraction weight 2^-(gi+1).
  for (genvar gi = 0; gi < LgQ; gi++) begin : g_mul
    localparam logic [30:0] RootC = 31'(edr_root_q30(gi + 1));
    logic [30:0] a_in;
    logic [27:0] f_in;
    side_t       s_in;
    logic [61:0] prod;

    if (gi == 0) begin : g_first
      assign a_in = 31'h4000_0000;
      assign f_in = frac_i;
      assign s_in = side_i;
    end else begin : g_next
      assign a_in = acc_q[gi-1];
      assign f_in = frac_q[gi-1];
      assign s_in = side_q[gi-1];
    end

    assign prod = 62'(a_in) * 62'(RootC);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[gi]  <= f_in[LgQ-1-gi] ? prod[60:30] : a_in;
        frac_q[gi] <= f_in;
        side_q[gi] <= s_in;
      end
    end
  end

  assign valid_o = vld_q[LgQ-1];
  assign pow_o   = acc_q[LgQ-1];
  assign side_o  = side_q[LgQ-1];

endmodule
`default_nettype wire

FILE: rtl/edr_check.sv
// Port-level checker for the dog-bone width recovery unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "edger_dog_bone_width_recovery_unit_assert.svh"
module edr_check (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tuser
);

  // An error beat carries zero factor and zero increase.
  `EDR_ASSERT_IMP(a_err_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[40:0] == 41'd0)

  // The factor never exceeds 1.0.
  `EDR_ASSERT_IMP(a_bf_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[40:24] <= 17'd65536)

  // A zero factor gives no width increase.
  `EDR_ASSERT_IMP(a_bf0_wi0, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[40:24] == 17'd0), m_axis_tdata[23:0] == 24'd0)

  // A stalled result beat holds.
  `EDR_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind edger_dog_bone_width_recovery_unit edr_check u_edr_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

FILE: verif/edger_dog_bone_width_recovery_unit_tb.sv
// Self-checking testbench of the dog-bone width recovery unit: random and directed slabs.
`timescale 1ns / 1ps
`default_nettype none

// Holds the bone-factor predictor and the queue of expected result beats.
class bone_scoreboard;
  logic [23:0] diam;
  logic [47:0] want_data[$];
  logic        want_err[$];
  int          mismatches;
  int          checked;

  function new();
    diam = edr_pkg::DiamReset;
    mismatches = 0;
    checked = 0;
  endfunction

  // log2 in Q28 by repeated squaring of the normalized mantissa.
  function automatic longint log2_q28(logic [23:0] x);
    int          p;
    logic [63:0] m;
    longint      frac;
    p = 23;
    frac = 0;
    while (p > 0 && x[p] == 1'b0) p--;
    m = 64'(x) << (31 - p);
    for (int i = 0; i < 28; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (longint'(p) << 28) + frac;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // 2^(f/2^28) in Q30, from a chain of square roots of two.
  function automatic logic [63:0] pow2_frac(logic [63:0] f);
    logic [63:0] acc;
    logic [63:0] r;
    acc = 64'd1 << 30;
    r = int_sqrt(64'd1 << 61);
    for (int i = 1; i <= 28; i++) begin
      if (f[28-i]) acc = (acc * r) >> 30;
      r = int_sqrt(r << 30);
    end
    return acc;
  endfunction

  function automatic logic [16:0] bone_factor(logic [23:0] wb, logic [23:0] wa,
                                              logic [23:0] h, logic [23:0] d);
    longint      lwb, ld, s, m, n;
    logic [63:0] u, e2, a, k, g;
    lwb = log2_q28(wb);
    ld = log2_q28(d);
    s = 64'sd1056965 * (log2_q28(wb - wa) - lwb)
      + 64'sd7398753 * (log2_q28(h) - ld)
      + 64'sd16592667 * (ld - lwb)
      + 64'sd127355847 * (lwb - log2_q28(wa));
    u = 64'(s) + (64'd1 << 62) + (64'd1 << 23);
    m = longint'(u >> 24) - (64'sd1 << 38) + 64'sd385794103;
    if (m >= (64'sd5 << 28)) return 17'd0;
    if (m < -(64'sd40 << 28)) begin
      e2 = 0;
    end else begin
      u = 64'(m + (64'sd64 << 28));
      n = longint'(u >> 28) - 64;
      a = pow2_frac(u & ((64'd1 << 28) - 1));
      if (n - 2 >= 0) e2 = a << (n - 2);
      else if (2 - n > 62) e2 = 0;
      else e2 = a >> (2 - n);
    end
    if (e2 >= (64'd18 << 28)) return 17'd0;
    k = e2 >> 28;
    g = e2 & ((64'd1 << 28) - 1);
    a = (g == 0) ? (64'd1 << 31) : pow2_frac((64'd1 << 28) - g);
    return 17'((a + (64'd1 << (14 + k))) >> (15 + k));
  endfunction

  // Notes an accepted slab beat and queues its expected result.
  function void note_slab(logic [71:0] beat);
    logic [23:0] wb, wa, h, diff, inc;
    logic [16:0] f;
    wb = beat[23:0];
    wa = beat[47:24];
    h = beat[71:48];
    if (wb == 0 || wa == 0 || wa > wb || diam == 0) begin
      want_data.push_back(48'd0);
      want_err.push_back(1'b1);
      return;
    end
    diff = wb - wa;
    if (diff == 0 || h == 0) f = 17'd65536;
    else f = bone_factor(wb, wa, h, diam);
    inc = 24'((64'(f) * diff + 32768) >> 16);
    want_data.push_back({7'd0, f, inc});
    want_err.push_back(1'b0);
  endfunction

  // Checks one result beat against the oldest expectation.
  function void check_result(logic [47:0] data, logic err);
    logic [47:0] wd;
    logic        we;
    checked++;
    if (want_data.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %h err %b", data, err);
      return;
    end
    wd = want_data.pop_front();
    we = want_err.pop_front();
    if (data !== wd || err !== we) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: inc %0d/%0d factor %0d/%0d pad %h/%h err %b/%b (exp/got)",
                 wd[23:0], data[23:0], wd[40:24], data[40:24], wd[47:41], data[47:41],
                 we, err);
    end
  endfunction
endclass

module edger_dog_bone_width_recovery_unit_tb;
  localparam int WatchLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [23:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;

  bone_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 1'b0;
  bit  timed_out = 1'b0;
  int  quiet_cycles = 0;
  int  sent = 0;

  edger_dog_bone_width_recovery_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: random stalls, sampling at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
  end
  always @(negedge clk_i) begin
    m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (rst_ni && quiet_cycles >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one slab beat and waits for it to be taken; the beat stays offered
  // until the next call or an explicit release, so back-to-back beats have no gap.
  task automatic send_slab(logic [23:0] wb, logic [23:0] wa, logic [23:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {h, wa, wb};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_slab({h, wa, wb});
    sent++;
    @(negedge clk_i);
  endtask

  // Writes the diameter once the pipe has drained.
  task automatic set_diameter(logic [23:0] d);
    s_axis_tvalid <= 1'b0;
    while (sb.want_data.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    cfg_wdata_i <= d;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.diam = d;
  endtask

  // Mostly realistic slabs with a modest reduction and a random height; the rest fully random or small.
  task automatic send_random(int count);
    logic [23:0] wb, wa, h;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: begin
          wb = 24'($urandom); wa = 24'($urandom); h = 24'($urandom);
        end
        1: begin
          wb = 24'($urandom_range(1000));
          wa = 24'($urandom_range(wb));
          h = 24'($urandom_range(1000));
        end
        default: begin
          wb = 24'($urandom_range(24'hFFFFFF, 256));
          wa = wb - 24'($urandom_range(wb >> 3));
          h = 24'($urandom);
        end
      endcase
      send_slab(wb, wa, h);
    end
  endtask

  initial begin
    int phase_pct[3][2] = '{'{19, 73}, '{73, 19}, '{0, 0}};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: invalid inputs, no reduction, zero height, field extremes.
    send_slab(24'd0, 24'd0, 24'd0);
    send_slab(24'd100, 24'd0, 24'd5);
    send_slab(24'd100, 24'd101, 24'd5);
    send_slab(24'd500, 24'd500, 24'd300);
    send_slab(24'd500, 24'd400, 24'd0);
    send_slab(24'hFFFFFF, 24'd1, 24'hFFFFFF);
    send_slab(24'hFFFFFF, 24'hFFFFFE, 24'd1);
    send_slab(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_slab(24'd2, 24'd1, 24'd1);
    send_slab(24'h0A0000, 24'h098000, 24'h010000);
    set_diameter(24'd0);
    send_slab(24'd500, 24'd400, 24'd300);
    set_diameter(24'hFFFFFF);
    send_slab(24'h0A0000, 24'h090000, 24'h020000);
    send_slab(24'hFFFFFF, 24'hFFFF00, 24'd1);
    set_diameter(24'd1);
    send_slab(24'hFFFFFF, 24'hFFFFF0, 24'hFFFFFF);

    // Long receiver hold so the pipe fills and stalls the input.
    set_diameter(24'h00C800);
    recv_hold = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        recv_hold = 1'b0;
      end
      send_random(150);
    join

    for (int p = 0; p < 3; p++) begin
      send_idle_pct = phase_pct[p][0];
      recv_idle_pct = phase_pct[p][1];
      set_diameter(p == 0 ? 24'h032000 : (p == 1 ? 24'($urandom) : 24'h7FFFFF));
      send_random(370);
    end

    // Drain, then let the latency run out.
    s_axis_tvalid <= 1'b0;
    while (sb.want_data.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("Sent %0d slab beats over eight diameter settings, checked %0d results.",
             sent, sb.checked);
    $display("Covered invalid, unity, zero-height and heavy-stall cases.");
    if (sb.mismatches == 0 && sb.want_data.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/edr_pkg.sv
rtl/edr_log2.sv
rtl/edr_exp2.sv
rtl/edger_dog_bone_width_recovery_unit.sv
rtl/edr_check.sv
verif/edger_dog_bone_width_recovery_unit_tb.sv
